FILE: hdl/ir_macro_record_playback_defines.svh
`ifndef IR_MACRO_RECORD_PLAYBACK_DEFINES_SVH
`define IR_MACRO_RECORD_PLAYBACK_DEFINES_SVH

// Assertion helpers; both expect clk and rst_n in scope.

// Condition must hold at every clock edge outside reset.
`define IRM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define IRM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/irm_pkg.sv
`timescale 1ns / 1ps

package irm_pkg;

    localparam int MACRO_DEPTH_DEF = 64;
    localparam int CODE_BITS_DEF   = 64;

    localparam int FUNC_W    = 3;
    localparam int STAMP_W   = 32;
    localparam int CODE_W    = 64;
    localparam int KIND_W    = 2;
    localparam int GAP_W     = 16;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_W-1:0] REPEAT_WINDOW_RST = 16'd500;
    localparam logic [CFG_W-1:0] MAX_WAIT_RST      = 16'(60 * 1000);

    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CODE      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REC_STOP  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PLAY      = 3'd4;

    localparam logic [KIND_W-1:0] KIND_SEND     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORDED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REC_DONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT      = 1'd1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_REC,
        MODE_PLAY
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [STAMP_W-1:0] now_ms;
        logic [CODE_W-1:0]  rx_code;
    } cmd_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  tx_code;
        logic [GAP_W-1:0]   gap_ms;
        logic               last_of_macro;
        logic [COUNT_W-1:0] entry_count;
    } rsp_word_t;

endpackage

FILE: hdl/irm_cmd_if.sv
`timescale 1ns / 1ps

interface irm_cmd_if;
    logic                valid;
    logic                ready;
    irm_pkg::cmd_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/irm_rsp_if.sv
`timescale 1ns / 1ps

interface irm_rsp_if;
    logic                valid;
    logic                ready;
    irm_pkg::rsp_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ir_macro_record_playback.sv
`timescale 1ns / 1ps
`include "ir_macro_record_playback_defines.svh"

// Timed macro recorder and player for remote-control codes. Each cmd word is
// one event (tick, start record, code received, stop record, start play) with
// a millisecond timestamp; each rsp word is a code to send, a code recorded,
// a code dropped on a full store, or the end of a recording. Results load on
// acceptance, but a tick that plays a code passes through ST_READ, since its
// code and the gap of the next entry come out of the store memories through
// registered reads. One event is in flight at a time. A new cmd word is taken
// once the rsp register is empty or being emptied in that cycle, so at most
// one result waits. The store needs no clearing after reset: playback only
// reads entries written by the current recording. The user must write
// configuration only while the block is idle; the block does not enforce it.
module ir_macro_record_playback #(
    parameter int MACRO_DEPTH = irm_pkg::MACRO_DEPTH_DEF,
    parameter int CODE_BITS   = irm_pkg::CODE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [irm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irm_pkg::CFG_W-1:0]     cfg_data,
    irm_cmd_if.sink                       cmd,
    irm_rsp_if.source                     rsp
);

    localparam int AW      = $clog2(MACRO_DEPTH);
    localparam int CW      = $clog2(MACRO_DEPTH + 1);
    localparam int ENTRY_W = CODE_BITS + irm_pkg::GAP_W;

    // Configuration registers
    logic [irm_pkg::CFG_W-1:0] repeat_win_reg;
    logic [irm_pkg::CFG_W-1:0] max_wait_reg;

    // Control state
    irm_pkg::state_t            st_reg, st_next;
    irm_pkg::mode_t             mode_reg, mode_next;
    logic [CW-1:0]              len_reg, len_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [irm_pkg::STAMP_W-1:0] deadline_reg, deadline_next;
    logic [CODE_BITS-1:0]       prev_code_reg, prev_code_next;
    logic [irm_pkg::STAMP_W-1:0] prev_stamp_reg, prev_stamp_next;
    logic                       out_valid_reg, out_valid_next;

    // Playing tick: held across the memory read
    logic [irm_pkg::STAMP_W-1:0] now_hold_reg, now_hold_next;
    logic                       last_hold_reg, last_hold_next;

    // Result register
    irm_pkg::rsp_word_t         out_word_reg, out_word_next;

    // Store: code with its own gap, and a gap copy read one entry ahead
    logic [ENTRY_W-1:0]         entry_mem [MACRO_DEPTH];
    logic [irm_pkg::GAP_W-1:0]  gap_mem   [MACRO_DEPTH];
    logic [ENTRY_W-1:0]         entry_rd_reg;
    logic [irm_pkg::GAP_W-1:0]  gap_rd_reg;

    logic                       mem_we;
    logic                       rd_en;
    logic [AW-1:0]              rd_ahead_idx;

    // Event decode helpers
    logic                       in_fire;
    logic [CODE_BITS-1:0]       code_in;
    logic [irm_pkg::STAMP_W-1:0] now_in;
    logic [irm_pkg::STAMP_W-1:0] diff_prev;
    logic [irm_pkg::STAMP_W-1:0] diff_deadline;
    logic [irm_pkg::STAMP_W-1:0] max_wait_ext;
    logic [irm_pkg::STAMP_W-1:0] gap_wide;
    logic [irm_pkg::GAP_W-1:0]   gap_clamped;
    logic                       is_repeat;
    logic                       store_full;
    logic                       reached;
    logic [CW-1:0]              pos_inc;
    logic [CW-1:0]              len_inc;

    assign in_fire       = cmd.valid && cmd.ready;
    assign code_in       = cmd.data.rx_code[CODE_BITS-1:0];
    assign now_in        = cmd.data.now_ms;
    assign diff_prev     = now_in - prev_stamp_reg;
    assign diff_deadline = now_in - deadline_reg;
    assign max_wait_ext  = irm_pkg::STAMP_W'(max_wait_reg);
    assign gap_wide      = (diff_prev < max_wait_ext) ? diff_prev : max_wait_ext;
    assign gap_clamped   = gap_wide[irm_pkg::GAP_W-1:0];
    assign is_repeat     = (code_in == prev_code_reg)
                           && (diff_prev < irm_pkg::STAMP_W'(repeat_win_reg));
    assign store_full    = (len_reg == CW'(MACRO_DEPTH));
    // Wrap-safe: deadline is reached while now - deadline stays in the lower half
    assign reached       = !diff_deadline[irm_pkg::STAMP_W-1];
    assign pos_inc       = pos_reg + CW'(1);
    assign len_inc       = len_reg + CW'(1);
    // Lookahead past the final entry is never used; keep the index in range
    assign rd_ahead_idx  = (pos_inc == CW'(MACRO_DEPTH)) ? '0 : pos_inc[AW-1:0];

    // Accept only with the result register free, so any result can land
    assign cmd.ready = (st_reg == irm_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_win_reg <= irm_pkg::REPEAT_WINDOW_RST;
            max_wait_reg   <= irm_pkg::MAX_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                irm_pkg::REG_REPEAT_WINDOW: repeat_win_reg <= cfg_data;
                irm_pkg::REG_MAX_WAIT:      max_wait_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Store memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[len_reg[AW-1:0]] <= {code_in, gap_clamped};
            gap_mem[len_reg[AW-1:0]]   <= gap_clamped;
        end
        if (rd_en)
        begin
            entry_rd_reg <= entry_mem[pos_reg[AW-1:0]];
            gap_rd_reg   <= gap_mem[rd_ahead_idx];
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= irm_pkg::ST_IDLE;
            mode_reg       <= irm_pkg::MODE_IDLE;
            len_reg        <= '0;
            pos_reg        <= '0;
            deadline_reg   <= '0;
            prev_code_reg  <= '0;
            prev_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            mode_reg       <= mode_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            deadline_reg   <= deadline_next;
            prev_code_reg  <= prev_code_next;
            prev_stamp_reg <= prev_stamp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_hold_reg  <= now_hold_next;
        last_hold_reg <= last_hold_next;
        out_word_reg  <= out_word_next;
    end

    // Event handling
    always_comb
    begin
        logic out_load;

        out_load        = 1'b0;
        st_next         = st_reg;
        mode_next       = mode_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        deadline_next   = deadline_reg;
        prev_code_next  = prev_code_reg;
        prev_stamp_next = prev_stamp_reg;
        now_hold_next   = now_hold_reg;
        last_hold_next  = last_hold_reg;
        out_word_next   = out_word_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;

        unique case (st_reg)
            irm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd.data.func)
                        irm_pkg::FUNC_TICK:
                        begin
                            if (mode_reg == irm_pkg::MODE_PLAY && reached)
                            begin
                                if (pos_reg >= len_reg)
                                begin
                                    mode_next = irm_pkg::MODE_IDLE;
                                end
                                else
                                begin
                                    // Fetch this entry and the next gap
                                    rd_en          = 1'b1;
                                    pos_next       = pos_inc;
                                    last_hold_next = (pos_inc == len_reg);
                                    now_hold_next  = now_in;
                                    st_next        = irm_pkg::ST_READ;
                                end
                            end
                        end
                        irm_pkg::FUNC_REC_START:
                        begin
                            len_next  = '0;
                            mode_next = irm_pkg::MODE_REC;
                        end
                        irm_pkg::FUNC_CODE:
                        begin
                            if (mode_reg == irm_pkg::MODE_REC && !is_repeat)
                            begin
                                out_load                    = 1'b1;
                                out_word_next.tx_code       = irm_pkg::CODE_W'(code_in);
                                out_word_next.gap_ms        = gap_clamped;
                                out_word_next.last_of_macro = 1'b0;
                                if (store_full)
                                begin
                                    out_word_next.kind        = irm_pkg::KIND_DROPPED;
                                    out_word_next.entry_count = irm_pkg::COUNT_W'(len_reg);
                                end
                                else
                                begin
                                    mem_we          = 1'b1;
                                    len_next        = len_inc;
                                    prev_code_next  = code_in;
                                    prev_stamp_next = now_in;
                                    out_word_next.kind        = irm_pkg::KIND_RECORDED;
                                    out_word_next.entry_count = irm_pkg::COUNT_W'(len_inc);
                                end
                            end
                        end
                        irm_pkg::FUNC_REC_STOP:
                        begin
                            if (mode_reg == irm_pkg::MODE_REC)
                            begin
                                mode_next                   = irm_pkg::MODE_IDLE;
                                out_load                    = 1'b1;
                                out_word_next.kind          = irm_pkg::KIND_REC_DONE;
                                out_word_next.tx_code       = '0;
                                out_word_next.gap_ms        = '0;
                                out_word_next.last_of_macro = 1'b0;
                                out_word_next.entry_count   = irm_pkg::COUNT_W'(len_reg);
                            end
                        end
                        irm_pkg::FUNC_PLAY:
                        begin
                            // Empty macro: ignore
                            if (len_reg != '0)
                            begin
                                pos_next      = '0;
                                deadline_next = now_in;
                                mode_next     = irm_pkg::MODE_PLAY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            irm_pkg::ST_READ:
            begin
                out_load                    = 1'b1;
                out_word_next.kind          = irm_pkg::KIND_SEND;
                out_word_next.tx_code       =
                    irm_pkg::CODE_W'(entry_rd_reg[ENTRY_W-1:irm_pkg::GAP_W]);
                out_word_next.gap_ms        = entry_rd_reg[irm_pkg::GAP_W-1:0];
                out_word_next.last_of_macro = last_hold_reg;
                out_word_next.entry_count   = irm_pkg::COUNT_W'(len_reg);
                if (last_hold_reg)
                begin
                    mode_next = irm_pkg::MODE_IDLE;
                end
                else
                begin
                    deadline_next = now_hold_reg + irm_pkg::STAMP_W'(gap_rd_reg);
                end
                st_next = irm_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = irm_pkg::ST_IDLE;
            end
        endcase

        // Hold the result until taken, then drop it
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // The result register is always free when the played entry arrives
    `IRM_ASSERT_IMPLY(a_read_slot_free, st_reg == irm_pkg::ST_READ, !out_valid_reg, "rsp register busy on store read")
    // Macro length never exceeds the store
    `IRM_ASSERT_ALWAYS(a_len_bound, len_reg <= CW'(MACRO_DEPTH), "macro length beyond store depth")
    // Between events, a running playback always has an entry left to play
    `IRM_ASSERT_IMPLY(a_play_pos, (st_reg == irm_pkg::ST_IDLE) && (mode_reg == irm_pkg::MODE_PLAY), pos_reg < len_reg, "playback position past macro end")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import irm_pkg::*;

    // Event codes with no meaning to the block; it must ignore them.
    localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_C = 3'd7;

    localparam int          STORE_DEPTH   = MACRO_DEPTH_DEF;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          PHASE_ITEMS   = 180;
    localparam logic [31:0] HALF_RANGE    = 32'h8000_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    irm_cmd_if cmd_bus ();
    irm_rsp_if rsp_bus ();

    ir_macro_record_playback i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus.sink),
        .rsp       (rsp_bus.source)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the recorder and its registers.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   win_ms;
    logic [CFG_W-1:0]   clamp_ms;
    mode_t              pb_mode;
    logic [CODE_W-1:0]  macro_codes [STORE_DEPTH];
    logic [GAP_W-1:0]   macro_gaps  [STORE_DEPTH];
    logic [COUNT_W-1:0] macro_len;
    logic [COUNT_W-1:0] play_idx;
    logic [STAMP_W-1:0] due_ms;
    logic [CODE_W-1:0]  kept_code;
    logic [STAMP_W-1:0] kept_stamp;

    cmd_word_t pending_events[$];
    rsp_word_t awaited_results[$];

    int fail_count  = 0;
    int cycle_count = 0;

    // Stimulus-side bookkeeping
    logic [STAMP_W-1:0] stamp_ms;
    logic [CODE_W-1:0]  code_pool [8];

    // Advance the recorder by one event and queue the rsp word it causes.
    function automatic void predict_macro_event(cmd_word_t w);
        rsp_word_t   r;
        logic [31:0] since;
        logic [31:0] gap;
        r = '0;
        case (w.func)
            FUNC_TICK:
            begin
                since = w.now_ms - due_ms;
                // Deadline counts as reached only within half the timestamp range.
                if (pb_mode == MODE_PLAY && since < HALF_RANGE)
                begin
                    if (play_idx >= macro_len)
                    begin
                        pb_mode = MODE_IDLE;
                    end
                    else
                    begin
                        r.kind    = KIND_SEND;
                        r.tx_code = macro_codes[play_idx];
                        r.gap_ms  = macro_gaps[play_idx];
                        play_idx  = play_idx + 1'b1;
                        r.last_of_macro = (play_idx == macro_len);
                        if (r.last_of_macro)
                            pb_mode = MODE_IDLE;
                        else
                            due_ms = w.now_ms + 32'(macro_gaps[play_idx]);
                        r.entry_count = macro_len;
                        awaited_results.push_back(r);
                    end
                end
            end
            FUNC_REC_START:
            begin
                macro_len = '0;
                pb_mode   = MODE_REC;
            end
            FUNC_CODE:
            begin
                since = w.now_ms - kept_stamp;
                if (pb_mode == MODE_REC &&
                    !(w.rx_code == kept_code && since < 32'(win_ms)))
                begin
                    gap = (since < 32'(clamp_ms)) ? since : 32'(clamp_ms);
                    r.tx_code = w.rx_code;
                    r.gap_ms  = gap[GAP_W-1:0];
                    if (macro_len >= STORE_DEPTH)
                    begin
                        // Store full: drop the code, keep the repeat filter as it was.
                        r.kind = KIND_DROPPED;
                    end
                    else
                    begin
                        macro_codes[macro_len] = w.rx_code;
                        macro_gaps[macro_len]  = gap[GAP_W-1:0];
                        macro_len  = macro_len + 1'b1;
                        kept_code  = w.rx_code;
                        kept_stamp = w.now_ms;
                        r.kind = KIND_RECORDED;
                    end
                    r.entry_count = macro_len;
                    awaited_results.push_back(r);
                end
            end
            FUNC_REC_STOP:
            begin
                if (pb_mode == MODE_REC)
                begin
                    pb_mode       = MODE_IDLE;
                    r.kind        = KIND_REC_DONE;
                    r.entry_count = macro_len;
                    awaited_results.push_back(r);
                end
            end
            FUNC_PLAY:
            begin
                // Playback of an empty macro leaves everything untouched.
                if (macro_len != 0)
                begin
                    play_idx = '0;
                    due_ms   = w.now_ms;
                    pb_mode  = MODE_PLAY;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Compare one accepted rsp word against the oldest expectation.
    function automatic void check_result(rsp_word_t got);
        rsp_word_t want;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected rsp word: kind %0d tx_code %h", got.kind, got.tx_code);
            fail_count++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
        end
        if (got.tx_code !== want.tx_code)
        begin
            $error("tx_code: expected %h, got %h", want.tx_code, got.tx_code);
            fail_count++;
        end
        if (got.gap_ms !== want.gap_ms)
        begin
            $error("gap_ms: expected %0d, got %0d", want.gap_ms, got.gap_ms);
            fail_count++;
        end
        if (got.last_of_macro !== want.last_of_macro)
        begin
            $error("last_of_macro: expected %0b, got %0b", want.last_of_macro,
                   got.last_of_macro);
            fail_count++;
        end
        if (got.entry_count !== want.entry_count)
        begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed cmd words from the pending queue. Hold a word until the
    // handshake completes, then possibly go idle before the next one. Every
    // 64 words decide whether idling is on at all, so that back-to-back
    // stretches occur too.
    // ------------------------------------------------------------------
    int src_idle_left = 0;
    int src_sent      = 0;
    bit src_idle_on   = 1'b1;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.data  <= '0;
        end
        else
        begin
            // Predict on acceptance, using the word as it stood at this edge.
            if (cmd_bus.valid && cmd_bus.ready)
                predict_macro_event(cmd_bus.data);

            if (cmd_bus.valid && !cmd_bus.ready)
            begin
                // Hold: word still waiting for the block.
            end
            else if (src_idle_left > 0)
            begin
                cmd_bus.valid <= 1'b0;
                src_idle_left--;
            end
            else if (pending_events.size() != 0)
            begin
                cmd_bus.valid <= 1'b1;
                cmd_bus.data  <= pending_events.pop_front();
                if (src_sent % 64 == 0)
                    src_idle_on = ($urandom_range(0, 2) != 0);
                src_sent++;
                src_idle_left = src_idle_on ? $urandom_range(0, 4) : 0;
            end
            else
            begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted rsp word, then possibly drop ready to stall.
    // ------------------------------------------------------------------
    int snk_stall_left = 0;
    int snk_taken      = 0;
    bit snk_stall_on   = 1'b1;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                check_result(rsp_bus.data);
                if (snk_taken % 64 == 0)
                    snk_stall_on = ($urandom_range(0, 2) != 0);
                snk_taken++;
                snk_stall_left = snk_stall_on ? $urandom_range(0, 4) : 0;
            end
            if (snk_stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                snk_stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put_event(logic [FUNC_W-1:0] f, logic [STAMP_W-1:0] t,
                             logic [CODE_W-1:0] c);
        cmd_word_t w;
        w.func    = f;
        w.now_ms  = t;
        w.rx_code = c;
        pending_events.push_back(w);
    endtask

    // Mostly draw from a small pool so that repeats and repeat filtering occur.
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 2) == 0)
            return {$urandom, $urandom};
        return code_pool[$urandom_range(0, 7)];
    endfunction

    // Write one register while the block is idle; mirror it in the predictor.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_REPEAT_WINDOW: win_ms   = val;
            REG_MAX_WAIT:      clamp_ms = val;
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every word is sent and answered, then let the pipe drain,
    // since the last event may have caused no result.
    task automatic wait_quiet();
        while (pending_events.size() != 0 || cmd_bus.valid ||
               awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Record n codes with random spacing; about one code in four repeats the last.
    task automatic record_macro(int n, bit with_stop);
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] prev;
        prev = pick_code();
        put_event(FUNC_REC_START, stamp_ms, {$urandom, $urandom});
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       stamp_ms += $urandom_range(0, 200000);
                1:       stamp_ms += $urandom_range(0, 32'(win_ms));
                default: stamp_ms += $urandom_range(0, 1500);
            endcase
            code = ($urandom_range(0, 3) == 0) ? prev : pick_code();
            put_event(FUNC_CODE, stamp_ms, code);
            prev = code;
        end
        stamp_ms += $urandom_range(0, 1000);
        if (with_stop)
            put_event(FUNC_REC_STOP, stamp_ms, {$urandom, $urandom});
    endtask

    // Start playback and follow with ticks; some fall behind the deadline.
    task automatic play_macro(int ticks);
        put_event(FUNC_PLAY, stamp_ms, {$urandom, $urandom});
        for (int i = 0; i < ticks; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                    put_event(FUNC_TICK, stamp_ms - $urandom_range(1, 1000),
                              {$urandom, $urandom});
                1:
                begin
                    stamp_ms += $urandom_range(0, 70000);
                    put_event(FUNC_TICK, stamp_ms, {$urandom, $urandom});
                end
                default:
                begin
                    stamp_ms += $urandom_range(0, 1500);
                    put_event(FUNC_TICK, stamp_ms, {$urandom, $urandom});
                end
            endcase
        end
    endtask

    // Random part: mostly whole record / play sequences, some broken ones,
    // and bursts of noise that do not count toward the quota.
    task automatic run_random(int quota);
        int done;
        int n;
        done = 0;
        while (done < quota)
        begin
            if ($urandom_range(0, 7) == 0)
                stamp_ms = $urandom;
            n = ($urandom_range(0, 14) == 0) ? $urandom_range(62, 68) :
                                               $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    record_macro(n, 1'b1);
                    play_macro(2 * n + 4);
                    done += 3 * n + 7;
                end
                7:
                begin
                    // Restart playback halfway, and play straight out of recording.
                    record_macro(n, 1'b1);
                    play_macro(n);
                    play_macro(2 * n + 4);
                    record_macro(n, 1'b0);
                    play_macro(2 * n + 4);
                    done += 7 * n + 14;
                end
                8:
                begin
                    // Abort playback by recording, then play an empty macro.
                    record_macro(n, 1'b1);
                    play_macro(n);
                    put_event(FUNC_REC_START, stamp_ms, {$urandom, $urandom});
                    put_event(FUNC_PLAY, stamp_ms, {$urandom, $urandom});
                    put_event(FUNC_TICK, stamp_ms, {$urandom, $urandom});
                    put_event(FUNC_REC_STOP, stamp_ms, {$urandom, $urandom});
                    put_event(FUNC_REC_STOP, stamp_ms, {$urandom, $urandom});
                    done += 2 * n + 8;
                end
                default:
                begin
                    repeat ($urandom_range(1, 6))
                        put_event(FUNC_W'($urandom_range(FUNC_TICK, FUNC_RSVD_C)),
                                  $urandom_range(0, 1) ? stamp_ms + $urandom_range(0, 3000)
                                                       : $urandom,
                                  {$urandom, $urandom});
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input known from time zero and hold reset.
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_REPEAT_WINDOW;
        cfg_data      = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.data  = '0;
        rsp_bus.ready = 1'b0;

        // Predictor comes up in its reset state.
        win_ms     = REPEAT_WINDOW_RST;
        clamp_ms   = MAX_WAIT_RST;
        pb_mode    = MODE_IDLE;
        macro_len  = '0;
        play_idx   = '0;
        due_ms     = '0;
        kept_code  = '0;
        kept_stamp = '0;

        code_pool[0] = '0;
        code_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            code_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at reset register values.
        // Events that must be ignored straight out of reset.
        put_event(FUNC_TICK,      32'd0, 64'h0);
        put_event(FUNC_PLAY,      32'd5, 64'h0);
        put_event(FUNC_REC_STOP,  32'd6, 64'h0);
        put_event(FUNC_CODE,      32'd7, 64'hAAAA_5555_0F0F_F0F0);
        put_event(FUNC_RSVD_A,    32'hFFFF_FFFF, '1);
        put_event(FUNC_RSVD_B,    32'hFFFF_FFFF, '1);
        put_event(FUNC_RSVD_C,    32'hFFFF_FFFF, '1);
        // Record: a zero code right away repeats the reset filter value and
        // is skipped; then a clamped gap, a skipped repeat, a repeat exactly
        // at the window, a huge gap and a gap across the timestamp wrap.
        put_event(FUNC_REC_START, 32'd100, 64'h0);
        put_event(FUNC_CODE,      32'd200, 64'h0);
        put_event(FUNC_CODE,      32'd700, 64'h0);
        put_event(FUNC_CODE,      32'd100700, '1);
        put_event(FUNC_CODE,      32'd101000, '1);
        put_event(FUNC_CODE,      32'd101200, '1);
        put_event(FUNC_CODE,      32'hFFFF_FF00, 64'h1234_5678_9ABC_DEF0);
        put_event(FUNC_CODE,      32'h0000_0010, 64'h0F0F_0F0F_0F0F_0F0F);
        put_event(FUNC_REC_STOP,  32'h0000_0020, 64'h0);
        // Play: a tick one ms early, the first code at once, a tick one ms
        // short of the gap, a tick half the range ahead (not reached), then on time.
        put_event(FUNC_PLAY,      32'h30, 64'h0);
        put_event(FUNC_TICK,      32'h2F, 64'h0);
        put_event(FUNC_TICK,      32'h30, 64'h0);
        put_event(FUNC_TICK,      32'h30 + 32'd59999, 64'h0);
        put_event(FUNC_TICK,      32'h30 + 32'd60000 + HALF_RANGE, 64'h0);
        put_event(FUNC_TICK,      32'h30 + 32'd60000, 64'h0);
        // Recording aborts playback; playing the now empty macro is ignored.
        put_event(FUNC_REC_START, 32'h30 + 32'd60100, 64'h0);
        put_event(FUNC_PLAY,      32'h30 + 32'd60200, 64'h0);
        put_event(FUNC_REC_STOP,  32'h30 + 32'd60300, 64'h0);
        stamp_ms = 32'h30 + 32'd60400;
        wait_quiet();

        // Random phases at several register settings, extremes included.
        run_random(PHASE_ITEMS);
        wait_quiet();

        write_reg(REG_REPEAT_WINDOW, '0);
        write_reg(REG_MAX_WAIT, '0);
        run_random(PHASE_ITEMS);
        wait_quiet();

        write_reg(REG_REPEAT_WINDOW, '1);
        write_reg(REG_MAX_WAIT, '1);
        run_random(PHASE_ITEMS);
        wait_quiet();

        write_reg(REG_REPEAT_WINDOW, 16'($urandom));
        write_reg(REG_MAX_WAIT, 16'($urandom));
        run_random(PHASE_ITEMS);
        wait_quiet();

        // Short clamp makes most gaps saturate.
        write_reg(REG_MAX_WAIT, 16'd700);
        write_reg(REG_REPEAT_WINDOW, 16'd300);
        run_random(PHASE_ITEMS);
        wait_quiet();

        if (awaited_results.size() != 0)
        begin
            $error("%0d expected rsp words never arrived", awaited_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: ir_macro_record_playback.f
+incdir+hdl
hdl/irm_pkg.sv
hdl/irm_cmd_if.sv
hdl/irm_rsp_if.sv
hdl/ir_macro_record_playback.sv
sim/tb_top.sv
